>>> src/lzhc_pkg.sv
// Shared types and constants for the LZ77 hash-chain table block.
// Used by lzhc_ctrl, lzhc_tables and lz77_hash_chain_table_top.
package lzhc_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_HASH_WIDTH    = 15;
	localparam int DEF_WINDOW_SIZE   = 32768;
	localparam int DEF_MIN_MATCH_LEN = 3;

	// Fixed field widths
	localparam int FUNC_W     = 3;
	localparam int BYTE_W     = 8;
	localparam int POS_W      = 16;
	localparam int OUT_HASH_W = 15;
	localparam int HASH_MAX_W = 16;
	// Sweep index: must hold the largest table depth itself (2^16)
	localparam int IDX_W      = 17;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_FEED   = 3'd0,
		FN_INSERT = 3'd1,
		FN_NEXT   = 3'd2,
		FN_SLIDE  = 3'd3,
		FN_CLEAR  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SLIDE,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		TM_NONE,
		TM_CLEAR,
		TM_SLIDE,
		TM_INS_RD,
		TM_INS_WR,
		TM_FOL_RD
	} tmode_t;

	// Command from the controller to the table memories
	typedef struct packed {
		tmode_t                  mode;
		logic [IDX_W-1:0]        idx;
		logic [HASH_MAX_W-1:0]   hash;
		logic [POS_W-1:0]        pos;
	} tbl_cmd_t;

endpackage

>>> src/lzhc_tables.sv
// Head and prev table memories with read, insert write-back and the sweep
// used for clearing and window slides. Depends on lzhc_pkg.
module lzhc_tables #(
	parameter int HASH_WIDTH  = lzhc_pkg::DEF_HASH_WIDTH,
	parameter int WINDOW_SIZE = lzhc_pkg::DEF_WINDOW_SIZE
) (
	input  logic                          clk,
	input  lzhc_pkg::tbl_cmd_t            cmd,
	output logic [lzhc_pkg::POS_W-1:0]    head_rdata,
	output logic [lzhc_pkg::POS_W-1:0]    prev_rdata
);

	localparam int HEAD_DEPTH = 1 << HASH_WIDTH;
	localparam int WIN_AW     = $clog2(WINDOW_SIZE);
	localparam logic [lzhc_pkg::IDX_W-1:0] HEAD_N = lzhc_pkg::IDX_W'(HEAD_DEPTH);
	localparam logic [lzhc_pkg::IDX_W-1:0] WIN_N  = lzhc_pkg::IDX_W'(WINDOW_SIZE);

	logic [lzhc_pkg::POS_W-1:0] head_mem [HEAD_DEPTH];
	logic [lzhc_pkg::POS_W-1:0] prev_mem [WINDOW_SIZE];

	logic                       head_re, head_we, prev_re, prev_we;
	logic [HASH_WIDTH-1:0]      head_ra, head_wa;
	logic [WIN_AW-1:0]          prev_ra, prev_wa;
	logic [lzhc_pkg::POS_W-1:0] head_wd, prev_wd;
	logic [lzhc_pkg::IDX_W-1:0] idx_m1;

	// Subtract the window from a stored position, clamp at zero
	function automatic logic [lzhc_pkg::POS_W-1:0] slid(input logic [lzhc_pkg::POS_W-1:0] v);
		logic [lzhc_pkg::IDX_W-1:0] vx;
		vx = lzhc_pkg::IDX_W'(v);
		if (vx >= WIN_N) begin
			slid = lzhc_pkg::POS_W'(vx - WIN_N);
		end else begin
			slid = '0;
		end
	endfunction

	assign idx_m1 = cmd.idx - lzhc_pkg::IDX_W'(1);

	always_comb begin
		head_re = 1'b0;
		head_we = 1'b0;
		prev_re = 1'b0;
		prev_we = 1'b0;
		head_ra = cmd.hash[HASH_WIDTH-1:0];
		head_wa = cmd.hash[HASH_WIDTH-1:0];
		prev_ra = cmd.pos[WIN_AW-1:0];
		prev_wa = cmd.pos[WIN_AW-1:0];
		head_wd = cmd.pos;
		prev_wd = head_rdata;
		case (cmd.mode)
			lzhc_pkg::TM_CLEAR: begin
				head_we = cmd.idx < HEAD_N;
				prev_we = cmd.idx < WIN_N;
				head_wa = cmd.idx[HASH_WIDTH-1:0];
				prev_wa = cmd.idx[WIN_AW-1:0];
				head_wd = '0;
				prev_wd = '0;
			end
			lzhc_pkg::TM_SLIDE: begin
				// read entry idx, write back entry idx-1 from last cycle's read
				head_re = cmd.idx < HEAD_N;
				prev_re = cmd.idx < WIN_N;
				head_ra = cmd.idx[HASH_WIDTH-1:0];
				prev_ra = cmd.idx[WIN_AW-1:0];
				head_we = (cmd.idx != '0) && (idx_m1 < HEAD_N);
				prev_we = (cmd.idx != '0) && (idx_m1 < WIN_N);
				head_wa = idx_m1[HASH_WIDTH-1:0];
				prev_wa = idx_m1[WIN_AW-1:0];
				head_wd = slid(head_rdata);
				prev_wd = slid(prev_rdata);
			end
			lzhc_pkg::TM_INS_RD: begin
				head_re = 1'b1;
			end
			lzhc_pkg::TM_INS_WR: begin
				head_we = 1'b1;
				prev_we = 1'b1;
			end
			lzhc_pkg::TM_FOL_RD: begin
				prev_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		if (head_re) begin
			head_rdata <= head_mem[head_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (prev_re) begin
			prev_rdata <= prev_mem[prev_ra];
		end
	end

endmodule

>>> src/lzhc_ctrl.sv
// Request sequencer: rolling hash, table command generation, result
// register with a pending slot. Depends on lzhc_pkg.
module lzhc_ctrl #(
	parameter int HASH_WIDTH    = lzhc_pkg::DEF_HASH_WIDTH,
	parameter int WINDOW_SIZE   = lzhc_pkg::DEF_WINDOW_SIZE,
	parameter int MIN_MATCH_LEN = lzhc_pkg::DEF_MIN_MATCH_LEN
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lzhc_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [lzhc_pkg::FUNC_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lzhc_pkg::M_TDATA_W-1:0]    m_tdata,
	output lzhc_pkg::tbl_cmd_t                cmd,
	input  logic [lzhc_pkg::POS_W-1:0]        head_rdata,
	input  logic [lzhc_pkg::POS_W-1:0]        prev_rdata
);

	localparam int SHIFT      = (HASH_WIDTH + MIN_MATCH_LEN - 1) / MIN_MATCH_LEN;
	localparam int HEAD_DEPTH = 1 << HASH_WIDTH;
	localparam int SWEEP_MAX  = (HEAD_DEPTH > WINDOW_SIZE) ? HEAD_DEPTH : WINDOW_SIZE;
	localparam logic [lzhc_pkg::IDX_W-1:0] SWEEP_N    = lzhc_pkg::IDX_W'(SWEEP_MAX);
	localparam logic [lzhc_pkg::IDX_W-1:0] SWEEP_LAST = lzhc_pkg::IDX_W'(SWEEP_MAX - 1);

	lzhc_pkg::state_t state_q, state_d;
	lzhc_pkg::func_t  func_in;
	logic             func_ins_s1;

	logic [lzhc_pkg::IDX_W-1:0]      cnt_q;
	logic [HASH_WIDTH-1:0]           hash_q, hash_d, hash_rolled;
	logic [lzhc_pkg::POS_W-1:0]      pos_s1;
	logic [lzhc_pkg::BYTE_W-1:0]     byte_in;
	logic [lzhc_pkg::POS_W-1:0]      position;

	logic                            out_valid_q;
	logic [lzhc_pkg::POS_W-1:0]      out_chain_q, pend_chain_q, res_chain;
	logic [lzhc_pkg::OUT_HASH_W-1:0] out_hash_q, pend_hash_q, res_hash;
	logic                            accept, out_free, load_out, load_pend;

	assign func_in  = lzhc_pkg::func_t'(s_tuser);
	assign byte_in  = s_tdata[lzhc_pkg::BYTE_W-1:0];
	assign position = s_tdata[lzhc_pkg::BYTE_W +: lzhc_pkg::POS_W];

	assign s_tready = (state_q == lzhc_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign hash_rolled = (hash_q << SHIFT) ^ HASH_WIDTH'(byte_in);

	// Hash after the accepted request
	always_comb begin
		hash_d = hash_q;
		if (accept) begin
			case (func_in)
				lzhc_pkg::FN_FEED, lzhc_pkg::FN_INSERT: hash_d = hash_rolled;
				lzhc_pkg::FN_CLEAR:                     hash_d = '0;
				default:                                hash_d = hash_q;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzhc_pkg::ST_CLEAR: begin
				if (cnt_q == SWEEP_LAST) state_d = lzhc_pkg::ST_IDLE;
			end
			lzhc_pkg::ST_IDLE: begin
				if (accept) begin
					case (func_in)
						lzhc_pkg::FN_INSERT, lzhc_pkg::FN_NEXT: state_d = lzhc_pkg::ST_READ;
						lzhc_pkg::FN_SLIDE:  state_d = lzhc_pkg::ST_SLIDE;
						default: state_d = out_free ? lzhc_pkg::ST_IDLE : lzhc_pkg::ST_EMIT;
					endcase
				end
			end
			lzhc_pkg::ST_READ: begin
				state_d = out_free ? lzhc_pkg::ST_IDLE : lzhc_pkg::ST_EMIT;
			end
			lzhc_pkg::ST_SLIDE: begin
				if (cnt_q == SWEEP_N) begin
					state_d = out_free ? lzhc_pkg::ST_IDLE : lzhc_pkg::ST_EMIT;
				end
			end
			lzhc_pkg::ST_EMIT: begin
				if (out_free) state_d = lzhc_pkg::ST_IDLE;
			end
			default: state_d = lzhc_pkg::ST_IDLE;
		endcase
	end

	// Outputs: table command and result routing
	always_comb begin
		cmd.mode  = lzhc_pkg::TM_NONE;
		cmd.idx   = cnt_q;
		cmd.hash  = lzhc_pkg::HASH_MAX_W'(hash_q);
		cmd.pos   = pos_s1;
		res_chain = '0;
		res_hash  = lzhc_pkg::OUT_HASH_W'(hash_q);
		load_out  = 1'b0;
		load_pend = 1'b0;
		case (state_q)
			lzhc_pkg::ST_CLEAR: begin
				cmd.mode = lzhc_pkg::TM_CLEAR;
			end
			lzhc_pkg::ST_IDLE: begin
				res_hash = lzhc_pkg::OUT_HASH_W'(hash_d);
				if (accept) begin
					case (func_in)
						lzhc_pkg::FN_INSERT: begin
							cmd.mode = lzhc_pkg::TM_INS_RD;
							cmd.hash = lzhc_pkg::HASH_MAX_W'(hash_d);
						end
						lzhc_pkg::FN_NEXT: begin
							cmd.mode = lzhc_pkg::TM_FOL_RD;
							cmd.pos  = position;
						end
						lzhc_pkg::FN_SLIDE: begin
						end
						default: begin
							load_out  = out_free;
							load_pend = !out_free;
						end
					endcase
				end
			end
			lzhc_pkg::ST_READ: begin
				if (func_ins_s1) begin
					cmd.mode  = lzhc_pkg::TM_INS_WR;
					res_chain = head_rdata;
				end else begin
					res_chain = prev_rdata;
				end
				load_out  = out_free;
				load_pend = !out_free;
			end
			lzhc_pkg::ST_SLIDE: begin
				cmd.mode = lzhc_pkg::TM_SLIDE;
				if (cnt_q == SWEEP_N) begin
					load_out  = out_free;
					load_pend = !out_free;
				end
			end
			lzhc_pkg::ST_EMIT: begin
				res_chain = pend_chain_q;
				res_hash  = pend_hash_q;
				load_out  = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzhc_pkg::ST_CLEAR;
			cnt_q       <= '0;
			hash_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hash_q  <= hash_d;
			if ((state_q == lzhc_pkg::ST_CLEAR || state_q == lzhc_pkg::ST_SLIDE)
			    && state_d == state_q) begin
				cnt_q <= cnt_q + lzhc_pkg::IDX_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1      <= position;
			func_ins_s1 <= (func_in == lzhc_pkg::FN_INSERT);
		end
		if (load_out) begin
			out_chain_q <= res_chain;
			out_hash_q  <= res_hash;
		end
		if (load_pend) begin
			pend_chain_q <= res_chain;
			pend_hash_q  <= res_hash;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_hash_q, out_chain_q};

endmodule

>>> src/lz77_hash_chain_table_top.sv
// LZ77 hash-chain tables: one request in, one result out. S = max(2^HASH_WIDTH, WINDOW_SIZE).
// Insert and follow do a registered memory read, insert writing head and prev back in ST_READ;
// slide sweeps one entry per cycle. Throughput: feed/clear/unused 1 request per cycle while
// the output is free; insert, follow and slide finish before the next is taken; a result held
// in the output register plus one pending result stalls requests. Reset (arst_n low, async):
// clearing pass over S entries with s_tready low.
module lz77_hash_chain_table_top #(
	parameter int HASH_WIDTH    = lzhc_pkg::DEF_HASH_WIDTH,
	parameter int WINDOW_SIZE   = lzhc_pkg::DEF_WINDOW_SIZE,
	parameter int MIN_MATCH_LEN = lzhc_pkg::DEF_MIN_MATCH_LEN
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request side
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lzhc_pkg::S_TDATA_W-1:0] s_tdata,  // byte_in[7:0], position[23:8]
	input  logic [lzhc_pkg::FUNC_W-1:0]    s_tuser,  // func[2:0]
	// Result side
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lzhc_pkg::M_TDATA_W-1:0] m_tdata   // chain_pos[15:0], hash_value[30:16]
);

	// Command to the memories and their registered read data
	lzhc_pkg::tbl_cmd_t         cmd;
	logic [lzhc_pkg::POS_W-1:0] head_rdata;
	logic [lzhc_pkg::POS_W-1:0] prev_rdata;

	// Sequencer: holds the rolling hash, steps the clear and slide sweeps,
	// and owns the result register plus one pending slot.
	lzhc_ctrl #(
		.HASH_WIDTH    (HASH_WIDTH),
		.WINDOW_SIZE   (WINDOW_SIZE),
		.MIN_MATCH_LEN (MIN_MATCH_LEN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cmd        (cmd),
		.head_rdata (head_rdata),
		.prev_rdata (prev_rdata)
	);

	// Head table (per hash) and prev table (per window slot); registered reads.
	// Insert reads head in the accept cycle and writes head and prev the next,
	// so back-to-back requests never overlap on an entry.
	lzhc_tables #(
		.HASH_WIDTH  (HASH_WIDTH),
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_tables (
		.clk        (clk),
		.cmd        (cmd),
		.head_rdata (head_rdata),
		.prev_rdata (prev_rdata)
	);

endmodule
